// ===== rtl/hbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbcd_pkg
// Shared types and codes of the HTTP body chunk deframer.
// ----------------------------------------------------------------------------
package hbcd_pkg;

    localparam int unsigned LenWidth   = 32;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned SkipWidth  = 2;
    localparam int unsigned PhaseWidth = 3;

    // Parse phase codes.
    localparam logic [PhaseWidth-1:0] PH_START   = 3'd0;
    localparam logic [PhaseWidth-1:0] PH_FIXED   = 3'd1;
    localparam logic [PhaseWidth-1:0] PH_SIZE    = 3'd2;
    localparam logic [PhaseWidth-1:0] PH_CDATA   = 3'd3;
    localparam logic [PhaseWidth-1:0] PH_SKIP    = 3'd4;
    localparam logic [PhaseWidth-1:0] PH_TRAILER = 3'd5;
    localparam logic [PhaseWidth-1:0] PH_DONE    = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_CHUNKED_MODE = 1'b0;
    localparam logic CFG_BODY_LENGTH  = 1'b1;

    localparam logic [SkipWidth-1:0] CRLF_LEN = 2'd2;

    localparam logic [ByteWidth-1:0] CH_LF    = 8'h0A;
    localparam logic [ByteWidth-1:0] CH_CR    = 8'h0D;
    localparam logic [ByteWidth-1:0] CH_SPACE = 8'h20;
    localparam logic [ByteWidth-1:0] CH_TAB   = 8'h09;

    typedef struct packed {
        logic [PhaseWidth-1:0] phase;
        logic [LenWidth-1:0]   bytes_left;
        logic [LenWidth-1:0]   size_accum;
        logic                  size_digits_done;
        logic [SkipWidth-1:0]  skip_count;
        logic                  line_empty;
    } parse_state_t;

    typedef struct packed {
        logic                 body_valid;
        logic [ByteWidth-1:0] body_byte;
        logic                 finished;
        logic                 leftover;
    } parse_result_t;

    typedef struct packed {
        logic                chunked_mode;
        logic [LenWidth-1:0] body_length;
    } parse_cfg_t;

    localparam parse_state_t STATE_RESET = '{
        phase:            PH_START,
        bytes_left:       '0,
        size_accum:       '0,
        size_digits_done: 1'b0,
        skip_count:       '0,
        line_empty:       1'b1
    };

endpackage

// ===== rtl/hbcd_parse.sv =====
// ----------------------------------------------------------------------------
// hbcd_parse
// Next-state and result logic for one body byte.
// ----------------------------------------------------------------------------
module hbcd_parse
(
    input  hbcd_pkg::parse_cfg_t    cfg,
    input  hbcd_pkg::parse_state_t  cur,
    input  logic                    restart,
    input  logic [7:0]              data_byte,
    output hbcd_pkg::parse_state_t  nxt,
    output hbcd_pkg::parse_result_t res
);
    import hbcd_pkg::*;

    logic                 is_hex;
    logic [3:0]           hex_val;
    logic [LenWidth+3:0]  accum_wide;
    logic                 valid;
    logic                 left;
    parse_state_t         st;

    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (data_byte >= 8'h30 && data_byte <= 8'h39)
        begin
            hex_val = 4'(data_byte - 8'h30);
        end
        else if (data_byte >= 8'h61 && data_byte <= 8'h66)
        begin
            hex_val = 4'(data_byte - 8'h57);
        end
        else if (data_byte >= 8'h41 && data_byte <= 8'h46)
        begin
            hex_val = 4'(data_byte - 8'h37);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    always_comb
    begin
        st    = cur;
        valid = 1'b0;
        left  = 1'b0;

        // A new body starts on restart or on the first byte after reset.
        if (restart || cur.phase == PH_START)
        begin
            st.bytes_left       = '0;
            st.size_accum       = '0;
            st.size_digits_done = 1'b0;
            st.skip_count       = '0;
            st.line_empty       = 1'b1;
            if (cfg.chunked_mode)
            begin
                st.phase = PH_SIZE;
            end
            else if (cfg.body_length != '0)
            begin
                st.phase      = PH_FIXED;
                st.bytes_left = cfg.body_length;
            end
            else
            begin
                st.phase = PH_DONE;
            end
        end

        accum_wide = {st.size_accum, 4'b0000} + (LenWidth+4)'(hex_val);

        case (st.phase)
            PH_FIXED, PH_CDATA:
            begin
                valid = 1'b1;
                if (st.bytes_left != '0)
                begin
                    st.bytes_left = st.bytes_left - 1'b1;
                end
                if (st.bytes_left == '0)
                begin
                    if (st.phase == PH_FIXED)
                    begin
                        st.phase = PH_DONE;
                    end
                    else
                    begin
                        st.phase      = PH_SKIP;
                        st.skip_count = CRLF_LEN;
                    end
                end
            end
            PH_SKIP:
            begin
                if (st.skip_count != '0)
                begin
                    st.skip_count = st.skip_count - 1'b1;
                end
                if (st.skip_count == '0)
                begin
                    st.phase            = PH_SIZE;
                    st.size_accum       = '0;
                    st.size_digits_done = 1'b0;
                    st.line_empty       = 1'b1;
                end
            end
            PH_SIZE:
            begin
                if (data_byte == CH_LF)
                begin
                    if (st.size_accum == '0)
                    begin
                        st.phase = PH_TRAILER;
                    end
                    else
                    begin
                        st.phase      = PH_CDATA;
                        st.bytes_left = st.size_accum;
                    end
                    st.size_accum       = '0;
                    st.size_digits_done = 1'b0;
                    st.line_empty       = 1'b1;
                end
                else if (!st.size_digits_done)
                begin
                    if (is_hex)
                    begin
                        st.line_empty = 1'b0;
                        // Any carry out of the low word means the size saturates.
                        if (accum_wide[LenWidth+3:LenWidth] != 4'd0)
                        begin
                            st.size_accum = '1;
                        end
                        else
                        begin
                            st.size_accum = accum_wide[LenWidth-1:0];
                        end
                    end
                    else if (!(st.line_empty &&
                               (data_byte == CH_SPACE || data_byte == CH_TAB)))
                    begin
                        st.size_digits_done = 1'b1;
                    end
                end
            end
            PH_TRAILER:
            begin
                if (data_byte == CH_LF)
                begin
                    if (st.line_empty)
                    begin
                        st.phase = PH_DONE;
                    end
                    else
                    begin
                        st.line_empty = 1'b1;
                    end
                end
                else if (data_byte != CH_CR)
                begin
                    st.line_empty = 1'b0;
                end
            end
            default:
            begin
                left = 1'b1;
            end
        endcase

        nxt            = st;
        res.body_valid = valid;
        res.body_byte  = valid ? data_byte : 8'h00;
        res.finished   = (st.phase >= PH_DONE);
        res.leftover   = left;
    end

endmodule

// ===== rtl/http_body_chunk_deframer_core.sv =====
// ----------------------------------------------------------------------------
// http_body_chunk_deframer_core
// Strips fixed-length or chunked framing from an HTTP request body.
// ----------------------------------------------------------------------------
//   channel  handshake           payload
//   in       in_valid/in_stall   restart, data_byte
//   out      out_valid/out_stall body_valid, body_byte, finished, leftover
//   cfg      cfg_we              cfg_index, cfg_data
//
// One byte is taken per cycle; each transfer is held in the input register and
// its result is presented by the result register once the parse step moves it.
// The parse state is updated in the single step between those registers.
// The reset clears the handshake and parse state and the configuration.
// A stall on the output holds the result; the input stalls only when both
// registers are full and the output is stalled.
module http_body_chunk_deframer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        restart,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        body_valid,
    output logic [7:0]  body_byte,
    output logic        finished,
    output logic        leftover,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import hbcd_pkg::*;

    parse_cfg_t    cfg_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_res;
    parse_result_t res_reg;

    logic                 in_full_reg;
    logic                 in_restart_reg;
    logic [ByteWidth-1:0] in_byte_reg;
    logic                 out_full_reg;
    logic                 out_free;
    logic                 move;

    assign out_free = !out_full_reg || !out_stall;
    assign move     = in_full_reg && out_free;
    assign in_stall = in_full_reg && !out_free;

    hbcd_parse u_parse
    (
        .cfg       (cfg_reg),
        .cur       (state_reg),
        .restart   (in_restart_reg),
        .data_byte (in_byte_reg),
        .nxt       (state_next),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHUNKED_MODE: cfg_reg.chunked_mode <= cfg_data[0];
                CFG_BODY_LENGTH:  cfg_reg.body_length  <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end
        else
        begin
            if (!in_stall)
            begin
                in_full_reg <= in_valid;
            end
            if (out_free)
            begin
                out_full_reg <= in_full_reg;
            end
            if (move)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_restart_reg <= restart;
            in_byte_reg    <= data_byte;
        end
        if (move)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid  = out_full_reg;
    assign body_valid = res_reg.body_valid;
    assign body_byte  = res_reg.body_byte;
    assign finished   = res_reg.finished;
    assign leftover   = res_reg.leftover;

endmodule
